/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros sample on the rising edge of clk and are off while arst_n is low.
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lfu_pkg.sv */
package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W      = $clog2(ENTRIES + 1);
	localparam int CAP_W      = 5;
	localparam int KEY_W      = 32;
	localparam int DATA_W     = 32;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [OCC_W-1:0]      occ_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CAP_W-1:0]      cap_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic signed [DATA_W-1:0] data_t;

	localparam logic  OP_GET    = 1'b0;
	localparam logic  OP_PUT    = 1'b1;
	localparam cap_t  CAP_RESET = 5'd16;
	localparam data_t RD_MISS   = -32'sd1;

	typedef struct packed {
		logic  op;
		key_t  key;
		data_t value;
	} in_t;

	typedef struct packed {
		logic  hit;
		data_t read_value;
		logic  evicted;
		key_t  evicted_key;
	} out_t;

	typedef struct packed {
		logic   valid;
		key_t   key;
		data_t  data;
		count_t count;
		idx_t   rank;
	} entry_t;

	typedef struct packed {
		logic   en;
		logic   set_valid;
		idx_t   tgt;
		logic   age_all;
		idx_t   age_limit;
		key_t   key;
		logic   set_data;
		data_t  data;
		count_t count;
	} wr_cmd_t;

	typedef struct packed {
		logic   found;
		idx_t   found_idx;
		data_t  found_data;
		count_t found_count;
		idx_t   found_rank;
		logic   free_found;
		idx_t   free_idx;
		occ_t   used;
		logic   victim_found;
		idx_t   victim_idx;
		key_t   victim_key;
		count_t victim_count;
		idx_t   victim_rank;
	} scan_res_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	function automatic occ_t sat_cap(input cap_t c);
		if (int'(c) > ENTRIES) begin
			return occ_t'(ENTRIES);
		end
		return occ_t'(c);
	endfunction

endpackage

/* src/lfu_slot_store.sv */
module lfu_slot_store (
	input  logic              clk,
	input  logic              arst_n,
	input  lfu_pkg::idx_t     rd_idx,
	input  lfu_pkg::wr_cmd_t  cmd,
	output lfu_pkg::entry_t   rd_entry
);

	logic [lfu_pkg::ENTRIES-1:0] valid_q;
	lfu_pkg::key_t   key_q   [lfu_pkg::ENTRIES];
	lfu_pkg::data_t  data_q  [lfu_pkg::ENTRIES];
	lfu_pkg::count_t count_q [lfu_pkg::ENTRIES];
	lfu_pkg::idx_t   rank_q  [lfu_pkg::ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.en && cmd.set_valid) begin
			valid_q[cmd.tgt] <= 1'b1;
		end
	end

	// Entries newer than the limit (all on age_all) age by one; the target is newest.
	always_ff @(posedge clk) begin
		if (cmd.en) begin
			key_q[cmd.tgt]   <= cmd.key;
			count_q[cmd.tgt] <= cmd.count;
			rank_q[cmd.tgt]  <= '0;
			if (cmd.set_data) begin
				data_q[cmd.tgt] <= cmd.data;
			end
			for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
				if (valid_q[i] && (lfu_pkg::idx_t'(i) != cmd.tgt) &&
				    (cmd.age_all || (rank_q[i] < cmd.age_limit))) begin
					rank_q[i] <= lfu_pkg::idx_t'(rank_q[i] + 1'b1);
				end
			end
		end
	end

	assign rd_entry = '{
		valid: valid_q[rd_idx],
		key:   key_q[rd_idx],
		data:  data_q[rd_idx],
		count: count_q[rd_idx],
		rank:  rank_q[rd_idx]
	};

endmodule

/* src/lfu_scan_unit.sv */
module lfu_scan_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                step,
	input  lfu_pkg::idx_t       idx,
	input  lfu_pkg::entry_t     entry,
	input  lfu_pkg::key_t       key,
	output lfu_pkg::scan_res_t  res
);

	lfu_pkg::scan_res_t res_q;
	lfu_pkg::scan_res_t res_nxt;
	logic               lower;
	logic               older_tie;

	assign lower     = entry.count < res_q.victim_count;
	assign older_tie = (entry.count == res_q.victim_count) && (entry.rank > res_q.victim_rank);

	always_comb begin
		res_nxt = res_q;
		if (entry.valid) begin
			res_nxt.used = lfu_pkg::occ_t'(res_q.used + 1'b1);
			if (!res_q.found && (entry.key == key)) begin
				res_nxt.found       = 1'b1;
				res_nxt.found_idx   = idx;
				res_nxt.found_data  = entry.data;
				res_nxt.found_count = entry.count;
				res_nxt.found_rank  = entry.rank;
			end
			if (!res_q.victim_found || lower || older_tie) begin
				res_nxt.victim_found = 1'b1;
				res_nxt.victim_idx   = idx;
				res_nxt.victim_key   = entry.key;
				res_nxt.victim_count = entry.count;
				res_nxt.victim_rank  = entry.rank;
			end
		end else if (!res_q.free_found) begin
			res_nxt.free_found = 1'b1;
			res_nxt.free_idx   = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q <= '0;
		end else if (step) begin
			res_q <= res_nxt;
		end
	end

	assign res = res_q;

endmodule

/* src/lfu_cache_table_unit.sv */
// Each transaction runs a scan that reads one slot per cycle, every slot in order, through
// the shared key and count compare unit, then a table update that is held while the
// previous result has not yet been taken. A new transaction is accepted only once the
// table update is done.
// Reset: asynchronous, active low; all slots become empty and capacity returns to 16.
`include "assert_macros.svh"

module lfu_cache_table_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lfu_pkg::in_t         in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lfu_pkg::out_t        out_data,
	input  logic                 cfg_we,
	input  lfu_pkg::cap_t        cfg_wdata
);

	lfu_pkg::state_t    state_q;
	lfu_pkg::idx_t      scan_idx_q;
	lfu_pkg::in_t       req_q;
	lfu_pkg::cap_t      cap_q;
	logic               out_valid_q;
	lfu_pkg::out_t      out_q;

	lfu_pkg::entry_t    rd_entry;
	lfu_pkg::scan_res_t sr;
	lfu_pkg::wr_cmd_t   slot_cmd;
	lfu_pkg::out_t      result;
	lfu_pkg::occ_t      cap_eff;
	lfu_pkg::count_t    bumped_count;
	logic               in_accept;
	logic               commit;
	logic               cap_zero;
	logic               is_put;
	logic               need_evict;

	assign in_ready  = (state_q == lfu_pkg::ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign commit    = (state_q == lfu_pkg::ST_UPDATE) && (!out_valid_q || out_ready);

	assign cap_eff      = lfu_pkg::sat_cap(cap_q);
	assign cap_zero     = (cap_eff == '0);
	assign is_put       = (req_q.op == lfu_pkg::OP_PUT);
	assign need_evict   = !sr.found && ((sr.used >= cap_eff) || !sr.free_found);
	assign bumped_count = (sr.found_count == '1) ? sr.found_count :
	                      lfu_pkg::count_t'(sr.found_count + 1'b1);

	lfu_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (scan_idx_q),
		.cmd      (slot_cmd),
		.rd_entry (rd_entry)
	);

	lfu_scan_unit u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (in_accept),
		.step   (state_q == lfu_pkg::ST_SCAN),
		.idx    (scan_idx_q),
		.entry  (rd_entry),
		.key    (req_q.key),
		.res    (sr)
	);

	always_comb begin
		slot_cmd = '0;
		slot_cmd.key  = req_q.key;
		slot_cmd.data = req_q.value;
		if (sr.found && !cap_zero) begin
			slot_cmd.en        = commit;
			slot_cmd.tgt       = sr.found_idx;
			slot_cmd.age_limit = sr.found_rank;
			slot_cmd.set_data  = is_put;
			slot_cmd.count     = bumped_count;
		end else if (is_put && !cap_zero) begin
			slot_cmd.en        = commit;
			slot_cmd.set_valid = 1'b1;
			slot_cmd.tgt       = need_evict ? sr.victim_idx : sr.free_idx;
			slot_cmd.age_all   = !need_evict;
			slot_cmd.age_limit = sr.victim_rank;
			slot_cmd.set_data  = 1'b1;
			slot_cmd.count     = lfu_pkg::count_t'(1);
		end
	end

	always_comb begin
		result.hit         = sr.found;
		result.read_value  = (!is_put && sr.found) ? sr.found_data : lfu_pkg::RD_MISS;
		result.evicted     = is_put && !cap_zero && need_evict;
		result.evicted_key = result.evicted ? sr.victim_key : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lfu_pkg::ST_IDLE;
			scan_idx_q <= '0;
			cap_q      <= lfu_pkg::CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			case (state_q)
				lfu_pkg::ST_IDLE: begin
					if (in_accept) begin
						state_q    <= lfu_pkg::ST_SCAN;
						scan_idx_q <= '0;
					end
				end
				lfu_pkg::ST_SCAN: begin
					scan_idx_q <= lfu_pkg::idx_t'(scan_idx_q + 1'b1);
					if (scan_idx_q == lfu_pkg::idx_t'(lfu_pkg::ENTRIES - 1)) begin
						state_q <= lfu_pkg::ST_UPDATE;
					end
				end
				lfu_pkg::ST_UPDATE: begin
					if (commit) begin
						state_q <= lfu_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lfu_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q <= in_data;
		end
		if (commit) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LFU_ASSERT_NEXT(a_scan_start, in_valid && in_ready, (state_q == lfu_pkg::ST_SCAN) && (scan_idx_q == '0), "scan did not start at slot zero")
	`LFU_ASSERT_IMP(a_out_from_update, $rose(out_valid), $past(state_q == lfu_pkg::ST_UPDATE), "result appeared without a table update")
	`LFU_ASSERT_IMP(a_evict_on_put_miss, out_valid && out_data.evicted, !out_data.hit && (out_data.read_value == lfu_pkg::RD_MISS), "eviction reported on a hit or a get")

endmodule
